/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on aclk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define SMD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("sha1 digest check failed");

// Check that a condition never holds outside reset.
`define SMD_NEVER(lbl, expr) \
    `SMD_ASSERT(lbl, !(expr))

`endif

/* rtl/smd_pkg.sv */
// ----------------------------------------------------------------------------
// SHA-1 digest package
// Sequencer states, round constants, initial chaining values and helpers.
// ----------------------------------------------------------------------------
package smd_pkg;

    typedef enum logic [2:0] {
        ST_FILL,
        ST_PAD,
        ST_COMP,
        ST_FIN,
        ST_OUT
    } state_t;

    localparam logic [31:0] SHA_K0   = 32'h5A827999;
    localparam logic [31:0] SHA_K1   = 32'h6ED9EBA1;
    localparam logic [31:0] SHA_K2   = 32'h8F1BBCDC;
    localparam logic [31:0] SHA_K3   = 32'hCA62C1D6;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    localparam logic [31:0] INIT_WORDS [5] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [6:0] ROUNDS       = 7'd80;
    localparam logic [6:0] SCHED_START  = 7'd16;
    localparam logic [3:0] FILL_LAST    = 4'd15;
    localparam logic [3:0] FILL_LEN_HI  = 4'd14;
    localparam logic [2:0] DIGEST_LAST  = 3'd4;
    localparam logic [2:0] FULL_BYTES   = 3'd4;

    // Final word with fewer than four valid bytes: keep the valid bytes,
    // zero the rest, and put the pad marker right after them.
    function automatic logic [31:0] tail_word(input logic [31:0] data,
                                              input logic [2:0]  nbytes);
        logic [31:0] word;
        begin
            word = '0;
            case (nbytes)
                3'd0:    word = {PAD_BYTE, 24'h000000};
                3'd1:    word = {data[31:24], PAD_BYTE, 16'h0000};
                3'd2:    word = {data[31:16], PAD_BYTE, 8'h00};
                default: word = {data[31:8], PAD_BYTE};
            endcase
            return word;
        end
    endfunction

    function automatic logic [31:0] round_f(input logic [6:0]  t,
                                            input logic [31:0] b,
                                            input logic [31:0] c,
                                            input logic [31:0] d);
        logic [31:0] f;
        begin
            if (t < 7'd20) begin
                f = (b & c) | (~b & d);
            end else if (t < 7'd40) begin
                f = b ^ c ^ d;
            end else if (t < 7'd60) begin
                f = (b & c) | (b & d) | (c & d);
            end else begin
                f = b ^ c ^ d;
            end
            return f;
        end
    endfunction

    function automatic logic [31:0] round_k(input logic [6:0] t);
        logic [31:0] k;
        begin
            if (t < 7'd20) begin
                k = SHA_K0;
            end else if (t < 7'd40) begin
                k = SHA_K1;
            end else if (t < 7'd60) begin
                k = SHA_K2;
            end else begin
                k = SHA_K3;
            end
            return k;
        end
    endfunction

endpackage

/* rtl/sha1_message_digest.sv */
// ----------------------------------------------------------------------------
// sha1_message_digest: SHA-1 over big-endian 32-bit message words
// Throughput: one word per cycle while a block fills; input is held off
// while each 16-word block is compressed, each round reading its schedule
// words as two read pairs through the two read ports of the block buffer.
// After the final word come the padding writes and one or two compressions
// before the first digest word; five digest words follow.
// Reset (aresetn low, synchronous) restores the initial chaining values.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sha1_message_digest (
    input  logic        aclk,
    input  logic        aresetn,
    // message words
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_data_word,
    input  logic [2:0]  s_valid_bytes,
    input  logic        s_last_word,
    // digest words
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_last_digest
);

    // ------------------------------------------------------------------
    // Block buffer: 16 x 32 memory, one write port, two registered read
    // ports. It holds the message block and then serves as the rolling
    // schedule window: round t (t >= 16) overwrites entry t mod 16.
    // ------------------------------------------------------------------
    logic [31:0] buf_mem [16];
    logic        mem_we;
    logic [3:0]  mem_waddr;
    logic [31:0] mem_wdata;
    logic        rd_en;
    logic [3:0]  raddr0;
    logic [3:0]  raddr1;
    logic [31:0] rd0_reg;
    logic [31:0] rd1_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            buf_mem[mem_waddr] <= mem_wdata;
        end
        rd0_reg <= buf_mem[raddr0];
        rd1_reg <= buf_mem[raddr1];
    end

    // ------------------------------------------------------------------
    // Control and working state
    // ------------------------------------------------------------------
    smd_pkg::state_t state_reg, state_next;

    logic [31:0] wk_reg    [5];   // a, b, c, d, e
    logic [31:0] wk_next   [5];
    logic [31:0] chain_reg [5];
    logic [31:0] chain_next[5];

    logic [63:0] count_reg, count_next;     // message bytes so far
    logic [3:0]  fill_reg, fill_next;       // next buffer slot to fill
    logic [6:0]  rnd_reg, rnd_next;         // round whose reads are issued
    logic        phase_reg, phase_next;     // 0: first read pair, 1: second
    logic        ex_valid_reg, ex_valid_next;
    logic [6:0]  ex_t_reg, ex_t_next;       // round waiting to execute
    logic [31:0] xa_reg, xa_next;           // partial schedule XOR
    logic        pad_reg, pad_next;         // padding in progress
    logic        mark_reg, mark_next;       // pad marker word still owed
    logic        hi_done_reg, hi_done_next; // length high word written
    logic        final_reg, final_next;     // last block of the message
    logic [2:0]  out_idx_reg, out_idx_next;

    logic [63:0] bit_len;
    logic [2:0]  vb_clamp;
    logic [31:0] sched_w;
    logic [31:0] round_sum;
    logic        start_comp;

    assign bit_len  = {count_reg[60:0], 3'b000};
    assign vb_clamp = (s_valid_bytes > smd_pkg::FULL_BYTES) ? smd_pkg::FULL_BYTES
                                                            : s_valid_bytes;

    // Schedule word and round sum for the round that executes this cycle.
    always_comb begin
        logic [31:0] x;
        x = xa_reg ^ rd0_reg ^ rd1_reg;
        if (ex_t_reg < smd_pkg::SCHED_START) begin
            sched_w = xa_reg;
        end else begin
            sched_w = {x[30:0], x[31]};
        end
        round_sum = {wk_reg[0][26:0], wk_reg[0][31:27]}
                  + smd_pkg::round_f(ex_t_reg, wk_reg[1], wk_reg[2], wk_reg[3])
                  + wk_reg[4] + sched_w + smd_pkg::round_k(ex_t_reg);
    end

    // ------------------------------------------------------------------
    // Datapath: buffer writes, reads and register updates
    // ------------------------------------------------------------------
    always_comb begin
        mem_we        = 1'b0;
        mem_waddr     = fill_reg;
        mem_wdata     = '0;
        rd_en         = 1'b0;
        raddr0        = '0;
        raddr1        = '0;
        wk_next       = wk_reg;
        chain_next    = chain_reg;
        count_next    = count_reg;
        fill_next     = fill_reg;
        rnd_next      = rnd_reg;
        phase_next    = phase_reg;
        ex_valid_next = ex_valid_reg;
        ex_t_next     = ex_t_reg;
        xa_next       = xa_reg;
        pad_next      = pad_reg;
        mark_next     = mark_reg;
        hi_done_next  = hi_done_reg;
        final_next    = final_reg;
        out_idx_next  = out_idx_reg;
        start_comp    = 1'b0;

        unique case (state_reg)
            smd_pkg::ST_FILL: begin
                if (s_valid) begin
                    mem_we    = 1'b1;
                    fill_next = fill_reg + 4'd1;
                    if (!s_last_word) begin
                        // Words before the end always carry four bytes.
                        mem_wdata  = s_data_word;
                        count_next = count_reg + 64'd4;
                    end else begin
                        count_next = count_reg + 64'(vb_clamp);
                        pad_next   = 1'b1;
                        if (vb_clamp == smd_pkg::FULL_BYTES) begin
                            // Full final word: marker goes in a word of its own.
                            mem_wdata = s_data_word;
                            mark_next = 1'b1;
                        end else begin
                            mem_wdata = smd_pkg::tail_word(s_data_word, vb_clamp);
                        end
                    end
                    start_comp = (fill_reg == smd_pkg::FILL_LAST);
                end
            end

            smd_pkg::ST_PAD: begin
                mem_we    = 1'b1;
                fill_next = fill_reg + 4'd1;
                if (mark_reg) begin
                    mem_wdata = {smd_pkg::PAD_BYTE, 24'h000000};
                    mark_next = 1'b0;
                end else if (fill_reg == smd_pkg::FILL_LEN_HI) begin
                    mem_wdata    = bit_len[63:32];
                    hi_done_next = 1'b1;
                end else if (fill_reg == smd_pkg::FILL_LAST && hi_done_reg) begin
                    mem_wdata  = bit_len[31:0];
                    final_next = 1'b1;
                end else begin
                    mem_wdata = '0;
                end
                start_comp = (fill_reg == smd_pkg::FILL_LAST);
            end

            smd_pkg::ST_COMP: begin
                if (!phase_reg) begin
                    // Retire the pending round and write back its schedule word.
                    if (ex_valid_reg) begin
                        wk_next[4] = wk_reg[3];
                        wk_next[3] = wk_reg[2];
                        wk_next[2] = {wk_reg[1][1:0], wk_reg[1][31:2]};
                        wk_next[1] = wk_reg[0];
                        wk_next[0] = round_sum;
                        if (ex_t_reg >= smd_pkg::SCHED_START) begin
                            mem_we    = 1'b1;
                            mem_waddr = ex_t_reg[3:0];
                            mem_wdata = sched_w;
                        end
                    end
                    ex_valid_next = 1'b0;
                    if (rnd_reg != smd_pkg::ROUNDS) begin
                        // First pair: w[t-3] and w[t-8], or w[t] early on.
                        rd_en      = 1'b1;
                        raddr0     = (rnd_reg < smd_pkg::SCHED_START) ? rnd_reg[3:0]
                                                                      : rnd_reg[3:0] + 4'd13;
                        raddr1     = rnd_reg[3:0] + 4'd8;
                        phase_next = 1'b1;
                    end
                end else begin
                    // Second pair: w[t-14] and w[t-16].
                    rd_en         = 1'b1;
                    raddr0        = rnd_reg[3:0] + 4'd2;
                    raddr1        = rnd_reg[3:0];
                    xa_next       = (rnd_reg < smd_pkg::SCHED_START) ? rd0_reg
                                                                     : rd0_reg ^ rd1_reg;
                    ex_valid_next = 1'b1;
                    ex_t_next     = rnd_reg;
                    rnd_next      = rnd_reg + 7'd1;
                    phase_next    = 1'b0;
                end
            end

            smd_pkg::ST_FIN: begin
                for (int i = 0; i < 5; i++) begin
                    chain_next[i] = chain_reg[i] + wk_reg[i];
                end
            end

            smd_pkg::ST_OUT: begin
                if (m_ready) begin
                    if (out_idx_reg == smd_pkg::DIGEST_LAST) begin
                        // Digest delivered: start a fresh message.
                        chain_next   = smd_pkg::INIT_WORDS;
                        count_next   = '0;
                        fill_next    = '0;
                        pad_next     = 1'b0;
                        mark_next    = 1'b0;
                        hi_done_next = 1'b0;
                        final_next   = 1'b0;
                        out_idx_next = '0;
                    end else begin
                        out_idx_next = out_idx_reg + 3'd1;
                    end
                end
            end

            default: begin
            end
        endcase

        if (start_comp) begin
            wk_next       = chain_reg;
            rnd_next      = '0;
            phase_next    = 1'b0;
            ex_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            smd_pkg::ST_FILL: begin
                if (s_valid && fill_reg == smd_pkg::FILL_LAST) begin
                    state_next = smd_pkg::ST_COMP;
                end else if (s_valid && s_last_word) begin
                    state_next = smd_pkg::ST_PAD;
                end
            end
            smd_pkg::ST_PAD: begin
                if (fill_reg == smd_pkg::FILL_LAST) begin
                    state_next = smd_pkg::ST_COMP;
                end
            end
            smd_pkg::ST_COMP: begin
                if (!phase_reg && rnd_reg == smd_pkg::ROUNDS) begin
                    state_next = smd_pkg::ST_FIN;
                end
            end
            smd_pkg::ST_FIN: begin
                if (final_reg) begin
                    state_next = smd_pkg::ST_OUT;
                end else if (pad_reg) begin
                    state_next = smd_pkg::ST_PAD;
                end else begin
                    state_next = smd_pkg::ST_FILL;
                end
            end
            smd_pkg::ST_OUT: begin
                if (m_ready && out_idx_reg == smd_pkg::DIGEST_LAST) begin
                    state_next = smd_pkg::ST_FILL;
                end
            end
            default: state_next = smd_pkg::ST_FILL;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake outputs
    // ------------------------------------------------------------------
    always_comb begin
        s_ready = 1'b0;
        m_valid = 1'b0;
        unique case (state_reg)
            smd_pkg::ST_FILL: s_ready = 1'b1;
            smd_pkg::ST_OUT:  m_valid = 1'b1;
            default: begin
            end
        endcase
    end

    assign m_digest_word = chain_reg[out_idx_reg];
    assign m_word_index  = out_idx_reg;
    assign m_last_digest = (out_idx_reg == smd_pkg::DIGEST_LAST);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= smd_pkg::ST_FILL;
            chain_reg    <= smd_pkg::INIT_WORDS;
            count_reg    <= '0;
            fill_reg     <= '0;
            rnd_reg      <= '0;
            phase_reg    <= 1'b0;
            ex_valid_reg <= 1'b0;
            pad_reg      <= 1'b0;
            mark_reg     <= 1'b0;
            hi_done_reg  <= 1'b0;
            final_reg    <= 1'b0;
            out_idx_reg  <= '0;
        end else begin
            state_reg    <= state_next;
            chain_reg    <= chain_next;
            count_reg    <= count_next;
            fill_reg     <= fill_next;
            rnd_reg      <= rnd_next;
            phase_reg    <= phase_next;
            ex_valid_reg <= ex_valid_next;
            pad_reg      <= pad_next;
            mark_reg     <= mark_next;
            hi_done_reg  <= hi_done_next;
            final_reg    <= final_next;
            out_idx_reg  <= out_idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        wk_reg   <= wk_next;
        ex_t_reg <= ex_t_next;
        xa_reg   <= xa_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A schedule write-back never lands on an entry being read that cycle.
    `SMD_ASSERT(a_no_rw_overlap, (mem_we && rd_en) |-> (mem_waddr != raddr0 && mem_waddr != raddr1))
    // Input and output sides are never open at once.
    `SMD_NEVER(a_ready_valid_excl, s_ready && m_valid)
    // After the fifth digest word the block takes a new message.
    `SMD_ASSERT(a_restart, (m_valid && m_ready && m_last_digest) |=> (s_ready && fill_reg == '0))
    // The round counter stays within one block.
    `SMD_NEVER(a_round_range, rnd_reg > smd_pkg::ROUNDS)

endmodule

/* tb/sv/tb_sha1_message_digest.sv */
// ----------------------------------------------------------------------------
// tb_sha1_message_digest: self-checking regression for the SHA-1 digest block
// Feeds message words through the input channel and predicts each digest
// with a behavioral SHA-1 (padding, length, 80 rounds per block). Every
// digest word on the result channel is checked in order against the
// prediction. Both channels idle at random in phases, and the receiver
// stalls once for a long stretch to back the block up into its input.
// ----------------------------------------------------------------------------
module tb_sha1_message_digest;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 5;
    localparam int RANDOM_WORDS = 130;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 800;
    localparam int HOLD_AFTER   = 50;
    localparam int LIMIT_CYCLES = 400000;

    // One message word as it travels on the input channel.
    typedef struct packed {
        logic [31:0] data;
        logic [2:0]  nbytes;
        logic        last;
    } msg_word_t;

    // One digest word as it should appear on the result channel.
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_word_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [31:0] s_data_word   = '0;
    logic [2:0]  s_valid_bytes = '0;
    logic        s_last_word   = 1'b0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [31:0] m_digest_word;
    logic [2:0]  m_word_index;
    logic        m_last_digest;

    sha1_message_digest u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_word   (s_data_word),
        .s_valid_bytes (s_valid_bytes),
        .s_last_word   (s_last_word),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_digest_word (m_digest_word),
        .m_word_index  (m_word_index),
        .m_last_digest (m_last_digest)
    );

    always #(CLK_HALF) aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Behavioral SHA-1: chaining words, 16-word block / schedule window,
    // fill position and running byte count of the current message.
    // ------------------------------------------------------------------------
    logic [31:0] sha_chain [5];
    logic [31:0] sha_block [16];
    logic [3:0]  sha_fill;
    logic [63:0] sha_bytes;

    digest_word_t digest_expect_q [$];
    msg_word_t    word_q [$];
    msg_word_t    next_word;

    int words_taken    = 0;
    int digests_seen   = 0;
    int messages_done  = 0;
    int messages_queued = 0;
    int total_words    = 0;
    int failures       = 0;
    int cycle_count    = 0;
    int hold_left      = 0;
    bit hold_used      = 1'b0;

    // Start a fresh message: chaining words back to the initial values, block, fill and byte count cleared.
    task automatic sha1_restart();
        for (int i = 0; i < 5; i++) begin
            sha_chain[i] = smd_pkg::INIT_WORDS[i];
        end
        for (int i = 0; i < 16; i++) begin
            sha_block[i] = '0;
        end
        sha_fill  = '0;
        sha_bytes = '0;
    endtask

    // Run the 80 rounds over the full block and fold into the chaining words.
    task automatic sha1_compress();
        logic [31:0] a, b, c, d, e, f, k, w, sum;
        a = sha_chain[0];
        b = sha_chain[1];
        c = sha_chain[2];
        d = sha_chain[3];
        e = sha_chain[4];
        for (int t = 0; t < 80; t++) begin
            if (t >= 16) begin
                // Roll the schedule window in place.
                w = sha_block[(t - 3) % 16] ^ sha_block[(t - 8) % 16]
                  ^ sha_block[(t - 14) % 16] ^ sha_block[t % 16];
                w = {w[30:0], w[31]};
                sha_block[t % 16] = w;
            end else begin
                w = sha_block[t];
            end
            if (t < 20) begin
                f = (b & c) | (~b & d);
                k = smd_pkg::SHA_K0;
            end else if (t < 40) begin
                f = b ^ c ^ d;
                k = smd_pkg::SHA_K1;
            end else if (t < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = smd_pkg::SHA_K2;
            end else begin
                f = b ^ c ^ d;
                k = smd_pkg::SHA_K3;
            end
            sum = {a[26:0], a[31:27]} + f + e + w + k;
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = sum;
        end
        sha_chain[0] += a;
        sha_chain[1] += b;
        sha_chain[2] += c;
        sha_chain[3] += d;
        sha_chain[4] += e;
    endtask

    task automatic sha1_absorb(input logic [31:0] w);
        sha_block[sha_fill] = w;
        sha_fill = sha_fill + 4'd1;
        if (sha_fill == 4'd0) begin
            sha1_compress();
        end
    endtask

    // Account for one accepted word; on the final word pad, append the bit
    // length and queue the five digest words.
    task automatic sha1_take_word(input logic [31:0] data, input logic [2:0] nbytes,
                                  input logic last);
        int          n;
        logic [31:0] keep;
        logic [31:0] mark;
        logic [63:0] bits;
        digest_word_t dw;
        if (!last) begin
            // Byte count is ignored before the end: always four bytes.
            sha_bytes += 64'd4;
            sha1_absorb(data);
        end else begin
            n = (nbytes > 3'd4) ? 4 : int'(nbytes);
            sha_bytes += 64'(n);
            if (n == 4) begin
                sha1_absorb(data);
                sha1_absorb({smd_pkg::PAD_BYTE, 24'h000000});
            end else begin
                // Zero the unused bytes, then drop the pad marker behind the
                // valid ones.
                keep = (n == 0) ? 32'h0 : (32'hFFFFFFFF << (32 - 8 * n));
                mark = {smd_pkg::PAD_BYTE, 24'h000000} >> (8 * n);
                sha1_absorb((data & keep) | mark);
            end
            while (sha_fill != 4'd14) begin
                sha1_absorb(32'h0);
            end
            bits = sha_bytes << 3;
            sha1_absorb(bits[63:32]);
            sha1_absorb(bits[31:0]);
            for (int i = 0; i < 5; i++) begin
                dw.word  = sha_chain[i];
                dw.index = 3'(i);
                dw.last  = (3'(i) == smd_pkg::DIGEST_LAST);
                digest_expect_q.push_back(dw);
            end
            messages_done++;
            sha1_restart();
        end
    endtask

    // Idle percentage for each side in the current phase of the run.
    function automatic int idle_pct(input bit receiver);
        if (words_taken < total_words / 3) begin
            return receiver ? 66 : 34;
        end else if (words_taken < (2 * total_words) / 3) begin
            return receiver ? 34 : 66;
        end
        return 0;
    endfunction

    // Mostly random data, now and then all zeros or all ones.
    function automatic logic [31:0] pick_data();
        int r;
        r = $urandom_range(15);
        if (r == 0) begin
            return 32'h00000000;
        end else if (r == 1) begin
            return 32'hFFFFFFFF;
        end
        return $urandom();
    endfunction

    task automatic queue_word(input logic [31:0] data, input logic [2:0] nbytes,
                              input logic last);
        msg_word_t mw;
        mw.data   = data;
        mw.nbytes = nbytes;
        mw.last   = last;
        word_q.push_back(mw);
        total_words++;
        if (last) begin
            messages_queued++;
        end
    endtask

    // Queue a message of len words; byte counts on the body words are
    // random since the block must ignore them.
    task automatic queue_message(input int len);
        for (int i = 0; i < len - 1; i++) begin
            queue_word(pick_data(), 3'($urandom_range(7)), 1'b0);
        end
        queue_word(pick_data(), 3'($urandom_range(7)), 1'b1);
    endtask

    // ------------------------------------------------------------------------
    // Driver: present the next word, hold it until accepted, predict on accept.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                sha1_take_word(s_data_word, s_valid_bytes, s_last_word);
                words_taken <= words_taken + 1;
            end
            if (word_q.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
                next_word = word_q.pop_front();
                s_valid       <= 1'b1;
                s_data_word   <= next_word.data;
                s_valid_bytes <= next_word.nbytes;
                s_last_word   <= next_word.last;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver ready: random stalls, plus one long hold-off so the block
    // backs up and stalls its input while the driver keeps offering words.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left <= 0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_used && digests_seen >= HOLD_AFTER) begin
            hold_used <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= idle_pct(1'b1));
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check each accepted digest word against the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        digest_word_t want;
        if (aresetn && m_valid && m_ready) begin
            digests_seen <= digests_seen + 1;
            if (digest_expect_q.size() == 0) begin
                $display("%0t: unexpected digest word: expected none, actual %h idx %0d last %0b",
                         $time, m_digest_word, m_word_index, m_last_digest);
                failures++;
            end else begin
                want = digest_expect_q.pop_front();
                if (m_digest_word !== want.word) begin
                    $display("%0t: digest_word mismatch: expected %h, actual %h",
                             $time, want.word, m_digest_word);
                    failures++;
                end
                if (m_word_index !== want.index) begin
                    $display("%0t: word_index mismatch: expected %0d, actual %0d",
                             $time, want.index, m_word_index);
                    failures++;
                end
                if (m_last_digest !== want.last) begin
                    $display("%0t: last_digest mismatch: expected %0b, actual %0b",
                             $time, want.last, m_last_digest);
                    failures++;
                end
            end
        end
    end

    // Watchdog: stop a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d digest words outstanding",
                     cycle_count, digest_expect_q.size());
            $display("sha1_message_digest regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------------
    initial begin
        int r;
        int len;
        sha1_restart();

        // Empty message; the junk data must be dropped.
        queue_word(32'hFFFFFFFF, 3'd0, 1'b1);
        // Single-word messages over every byte count, including counts
        // above four that act as four.
        queue_word(32'hFFFFFFFF, 3'd1, 1'b1);
        queue_word(32'h616200FF, 3'd2, 1'b1);
        queue_word(32'h616263FF, 3'd3, 1'b1);
        queue_word(32'h00000000, 3'd4, 1'b1);
        queue_word(32'hFFFFFFFF, 3'd5, 1'b1);
        queue_word(32'h00000000, 3'd6, 1'b1);
        queue_word(32'h89ABCDEF, 3'd7, 1'b1);
        // Body words with partial counts still count as four bytes.
        queue_word(32'h00000000, 3'd1, 1'b0);
        queue_word(32'hFFFFFFFF, 3'd0, 1'b0);
        queue_word(32'h12345678, 3'd6, 1'b0);
        queue_word(32'hFFFFFFFF, 3'd2, 1'b1);

        // Random messages: mostly short, a good share sized around one and
        // two block boundaries so the pad and length spill into a new block.
        len = total_words;
        while (total_words - len < RANDOM_WORDS) begin
            r = $urandom_range(9);
            if (r < 6) begin
                queue_message($urandom_range(1, 8));
            end else if (r < 9) begin
                queue_message(16 * $urandom_range(0, 1) + $urandom_range(12, 17));
            end else begin
                queue_message($urandom_range(18, 40));
            end
        end

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        while (words_taken != total_words || digest_expect_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d messages (%0d words, byte counts 0..7, block-boundary tails)",
                 messages_queued, total_words);
        $display("checked %0d digest words under phased idling and one long output stall",
                 digests_seen);
        if (failures == 0) begin
            $display("sha1_message_digest regression: pass");
        end else begin
            $display("sha1_message_digest regression: fail");
        end
        $finish;
    end

endmodule
